// File: rtl/lbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bump-and-go controller package
// Shared types, constants and register indices for the laser bump-and-go
// controller: configuration bundle, queue entry and drive state encoding.
// ----------------------------------------------------------------------------
package lbg_pkg;

   localparam int INDEX_W = 10;
   localparam int RANGE_W = 16;
   localparam int SPEED_W = 12;
   localparam int CMD_W   = 13;
   localparam int TICK_W  = 16;
   localparam int CONE_W  = 17;
   localparam int LIMIT_W = 13;

   localparam logic [INDEX_W-1:0] CONE_LOW         = 10'd196;
   localparam logic [INDEX_W-1:0] CONE_HIGH        = 10'd470;
   localparam logic [INDEX_W-1:0] CENTER_INDEX     = 10'd333;
   localparam logic [INDEX_W-1:0] CENTER_TOLERANCE = 10'd3;
   localparam logic [LIMIT_W-1:0] MAX_SAMPLES      = 13'd1024;
   localparam logic [CONE_W-1:0]  CONE_INF         = 17'h1FFFF;
   localparam logic [TICK_W-1:0]  TICK_SAT         = 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_FLOOR   = 4'd0,
      CSR_RANGE_CEILING = 4'd1,
      CSR_OBSTACLE_DIST = 4'd2,
      CSR_SCAN_TIMEOUT  = 4'd3,
      CSR_BACKING_TICKS = 4'd4,
      CSR_LIN_SPEED     = 4'd5,
      CSR_ANG_SPEED     = 4'd6,
      CSR_ZERO_ANGLE    = 4'd7
   } lbg_csr_index_type;

   typedef enum logic [1:0] {
      DRIVE_FORWARD = 2'd0,
      DRIVE_BACK    = 2'd1,
      DRIVE_TURN    = 2'd2,
      DRIVE_STOP    = 2'd3
   } lbg_drive_state_type;

   typedef enum logic {
      ENTRY_PUBLISH = 1'b0,
      ENTRY_TICK    = 1'b1
   } lbg_entry_kind_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_floor;
      logic [RANGE_W-1:0] range_ceiling;
      logic [RANGE_W-1:0] obstacle_limit;
      logic [TICK_W-1:0]  scan_timeout_ticks;
      logic [TICK_W-1:0]  backing_ticks;
      logic [SPEED_W-1:0] lin_speed;
      logic [SPEED_W-1:0] ang_speed;
      logic [INDEX_W-1:0] zero_angle_index;
   } lbg_cfg_type;

   typedef struct packed {
      lbg_entry_kind_type kind;
      logic               obstacle;
      logic [INDEX_W-1:0] choice_idx;
      logic [INDEX_W-1:0] max_idx;
   } lbg_entry_type;

endpackage
`default_nettype wire

// File: rtl/lbg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bump-and-go scan front end
// Accepts samples and ticks, keeps the running cone minimum and maxima of the
// scan in progress, and queues a publish entry on the last sample and a tick
// entry on every tick.
// ----------------------------------------------------------------------------
module lbg_front (
   input  wire                               clock,
   input  wire                               reset,
   input  lbg_pkg::lbg_cfg_type              cfg,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [lbg_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                               req_tuser,
   input  wire                               req_tlast,
   output logic                              push_valid,
   input  wire                               push_ready,
   output lbg_pkg::lbg_entry_type            push_data
);
   import lbg_pkg::*;

   logic [CONE_W-1:0]  cone_min_ff, cone_min_in;
   logic [RANGE_W-1:0] all_max_ff, all_max_in;
   logic [INDEX_W-1:0] all_idx_ff, all_idx_in;
   logic [RANGE_W-1:0] out_max_ff, out_max_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;

   logic [INDEX_W-1:0] idx;
   logic [RANGE_W-1:0] rng;
   logic               fin;
   logic               usable;
   logic               in_cone;
   logic               max_in_cone;
   logic               obstacle;
   logic               take_sample;

   assign idx = req_tdata[INDEX_W-1:0];
   assign rng = req_tdata[INDEX_W+RANGE_W-1:INDEX_W];
   assign fin = req_tdata[INDEX_W+RANGE_W];

   assign usable  = fin && ({{(LIMIT_W-INDEX_W){1'b0}}, idx} < MAX_SAMPLES)
                    && (rng >= cfg.range_floor) && (rng <= cfg.range_ceiling);
   assign in_cone = (idx >= CONE_LOW) && (idx <= CONE_HIGH);

   // Running values including the current sample; the last sample of a scan
   // is folded in before the scan is published.
   always_comb begin
      cone_min_in = cone_min_ff;
      all_max_in  = all_max_ff;
      all_idx_in  = all_idx_ff;
      out_max_in  = out_max_ff;
      out_idx_in  = out_idx_ff;
      if (usable) begin
         if (in_cone && ({1'b0, rng} < cone_min_ff)) begin
            cone_min_in = {1'b0, rng};
         end
         if (rng > all_max_ff) begin
            all_max_in = rng;
            all_idx_in = idx;
         end
         if (!in_cone && (rng > out_max_ff)) begin
            out_max_in = rng;
            out_idx_in = idx;
         end
      end
   end

   assign max_in_cone = (all_idx_in >= CONE_LOW) && (all_idx_in <= CONE_HIGH);
   assign obstacle    = cone_min_in < {1'b0, cfg.obstacle_limit};

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && (req_tuser || req_tlast);
   assign take_sample = req_tvalid && req_tready && !req_tuser;

   always_comb begin
      push_data.kind       = req_tuser ? ENTRY_TICK : ENTRY_PUBLISH;
      push_data.obstacle   = obstacle;
      push_data.max_idx    = all_idx_in;
      push_data.choice_idx = (obstacle && max_in_cone && (out_max_in != '0))
                             ? out_idx_in : all_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cone_min_ff <= CONE_INF;
         all_max_ff  <= '0;
         all_idx_ff  <= '0;
         out_max_ff  <= '0;
         out_idx_ff  <= '0;
      end else if (take_sample) begin
         if (req_tlast) begin
            cone_min_ff <= CONE_INF;
            all_max_ff  <= '0;
            all_idx_ff  <= '0;
            out_max_ff  <= '0;
            out_idx_ff  <= '0;
         end else begin
            cone_min_ff <= cone_min_in;
            all_max_ff  <= all_max_in;
            all_idx_ff  <= all_idx_in;
            out_max_ff  <= out_max_in;
            out_idx_ff  <= out_idx_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/lbg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bump-and-go entry queue
// Small first-in first-out queue of publish and tick entries between the
// scan front end and the drive state machine.
// ----------------------------------------------------------------------------
module lbg_queue #(
   parameter int DEPTH = lbg_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   output logic                   push_ready,
   input  lbg_pkg::lbg_entry_type push_data,
   output logic                   pop_valid,
   input  wire                    pop_ready,
   output lbg_pkg::lbg_entry_type pop_data
);
   import lbg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   lbg_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/lbg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bump-and-go drive state machine
// Takes entries, holds the last published scan and, once one is held, steps
// the forward, back, turn and stop machine per tick, registering a command.
// ----------------------------------------------------------------------------
module lbg_back (
   input  wire                               clock,
   input  wire                               reset,
   input  lbg_pkg::lbg_cfg_type              cfg,
   input  wire                               pop_valid,
   output logic                              pop_ready,
   input  lbg_pkg::lbg_entry_type            pop_data,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [lbg_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lbg_pkg::*;

   lbg_drive_state_type state_ff, state_in;
   logic               turn_dir_ff, turn_dir_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic [TICK_W-1:0]  age_ff, age_in;
   logic               seen_ff, seen_in;
   logic               held_obst_ff, held_obst_in;
   logic [INDEX_W-1:0] held_choice_ff, held_choice_in;
   logic [INDEX_W-1:0] held_max_ff, held_max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               take;
   logic               tick;
   logic [TICK_W-1:0]  age_inc;
   logic [TICK_W-1:0]  ticks_inc;
   logic [INDEX_W-1:0] center_dist;
   logic [CMD_W-1:0]   lin_cmd;
   logic [CMD_W-1:0]   ang_cmd;
   logic [CMD_W-1:0]   lin_pos;
   logic [CMD_W-1:0]   ang_pos;

   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;
   assign tick      = take && (pop_data.kind == ENTRY_TICK) && seen_ff;

   assign age_inc   = (age_ff == TICK_SAT) ? age_ff : age_ff + 1'b1;
   assign ticks_inc = (ticks_ff == TICK_SAT) ? ticks_ff : ticks_ff + 1'b1;
   assign center_dist = (held_max_ff >= CENTER_INDEX) ? held_max_ff - CENTER_INDEX
                                                       : CENTER_INDEX - held_max_ff;
   assign lin_pos = {1'b0, cfg.lin_speed};
   assign ang_pos = {1'b0, cfg.ang_speed};

   always_comb begin
      state_in       = state_ff;
      turn_dir_in    = turn_dir_ff;
      ticks_in       = ticks_ff;
      age_in         = age_ff;
      seen_in        = seen_ff;
      held_obst_in   = held_obst_ff;
      held_choice_in = held_choice_ff;
      held_max_in    = held_max_ff;
      lin_cmd        = '0;
      ang_cmd        = '0;

      if (take && (pop_data.kind == ENTRY_PUBLISH)) begin
         held_obst_in   = pop_data.obstacle;
         held_choice_in = pop_data.choice_idx;
         held_max_in    = pop_data.max_idx;
         seen_in        = 1'b1;
         age_in         = '0;
      end else if (tick) begin
         age_in   = age_inc;
         ticks_in = ticks_inc;
         case (state_ff)
            DRIVE_FORWARD: begin
               lin_cmd = lin_pos;
               if (age_inc > cfg.scan_timeout_ticks) begin
                  state_in = DRIVE_STOP;
                  ticks_in = '0;
               end else begin
                  turn_dir_in = held_choice_ff >= cfg.zero_angle_index;
                  if (held_obst_ff) begin
                     state_in = DRIVE_BACK;
                     ticks_in = '0;
                  end
               end
            end
            DRIVE_BACK: begin
               lin_cmd = CMD_W'(0) - lin_pos;
               if (ticks_inc > cfg.backing_ticks) begin
                  state_in = DRIVE_TURN;
                  ticks_in = '0;
               end
            end
            DRIVE_TURN: begin
               ang_cmd = turn_dir_ff ? ang_pos : CMD_W'(0) - ang_pos;
               if (center_dist <= CENTER_TOLERANCE) begin
                  state_in = DRIVE_FORWARD;
                  ticks_in = '0;
               end
            end
            default: begin
               if (age_inc < cfg.scan_timeout_ticks) begin
                  state_in = DRIVE_FORWARD;
                  ticks_in = '0;
               end
            end
         endcase
      end

      rsp_valid_in = pop_ready ? tick : rsp_valid_ff;
      rsp_data_in  = tick ? {{(RSP_DATA_W-2-2*CMD_W-1){1'b0}}, turn_dir_in,
                             ang_cmd, lin_cmd, state_in}
                          : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= DRIVE_FORWARD;
         turn_dir_ff    <= 1'b1;
         ticks_ff       <= '0;
         age_ff         <= '0;
         seen_ff        <= 1'b0;
         held_obst_ff   <= 1'b0;
         held_choice_ff <= '0;
         held_max_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         turn_dir_ff    <= turn_dir_in;
         ticks_ff       <= ticks_in;
         age_ff         <= age_in;
         seen_ff        <= seen_in;
         held_obst_ff   <= held_obst_in;
         held_choice_ff <= held_choice_in;
         held_max_ff    <= held_max_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/laser_bump_go_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Laser bump-and-go controller
// Obstacle avoidance state machine fed by laser range samples and control
// ticks, with a register write port for its thresholds and speeds.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, samples and ticks alike,
// while its queue has room. Samples update the running scan statistics in the
// front end in the cycle they are taken; the last sample of a scan and every
// tick place an entry in a queue of QUEUE_DEPTH entries, which the drive state
// machine drains at one entry per cycle whenever its output register is free.
// A tick that yields a command is held in the queue and then in the output
// register of the drive state machine before the result channel can accept it.
// Ticks before the first complete scan give no result.
// Registers may be written only while the block is idle; the write channel is
// always ready.
module laser_bump_go_controller #(
   parameter int QUEUE_DEPTH = lbg_pkg::QUEUE_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: sample_index[9:0], sample_range[25:10], sample_finite[26]
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [lbg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: req_type (0 sample, 1 tick); req_tlast: sample_last
   input  wire                               req_tuser,
   input  wire                               req_tlast,
   // rsp_tdata: drive_state[1:0], linear_cmd[14:2], angular_cmd[27:15],
   //            turn_left[28]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [lbg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [lbg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [lbg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lbg_pkg::*;

   lbg_cfg_type   cfg_ff;
   lbg_entry_type push_data;
   lbg_entry_type pop_data;
   logic          push_valid;
   logic          push_ready;
   logic          pop_valid;
   logic          pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_floor        <= 16'd100;
         cfg_ff.range_ceiling      <= 16'd30000;
         cfg_ff.obstacle_limit     <= 16'd1000;
         cfg_ff.scan_timeout_ticks <= 16'd20;
         cfg_ff.backing_ticks      <= 16'd40;
         cfg_ff.lin_speed          <= 12'd300;
         cfg_ff.ang_speed          <= 12'd300;
         cfg_ff.zero_angle_index   <= 10'd333;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANGE_FLOOR:   cfg_ff.range_floor        <= csr_data;
            CSR_RANGE_CEILING: cfg_ff.range_ceiling      <= csr_data;
            CSR_OBSTACLE_DIST: cfg_ff.obstacle_limit     <= csr_data;
            CSR_SCAN_TIMEOUT:  cfg_ff.scan_timeout_ticks <= csr_data;
            CSR_BACKING_TICKS: cfg_ff.backing_ticks      <= csr_data;
            CSR_LIN_SPEED:     cfg_ff.lin_speed          <= csr_data[SPEED_W-1:0];
            CSR_ANG_SPEED:     cfg_ff.ang_speed          <= csr_data[SPEED_W-1:0];
            CSR_ZERO_ANGLE:    cfg_ff.zero_angle_index   <= csr_data[INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lbg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lbg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lbg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: tb/laser_bump_go_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Laser bump-and-go controller testbench
// Streams laser samples and control ticks into the controller under several
// register settings, predicts every drive command from a behavioural copy of
// the scan tracking and the drive state machine, and compares each command
// field by field as it leaves the block.
// ----------------------------------------------------------------------------
module laser_bump_go_controller_test;
   import lbg_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd11;

   typedef struct {
      bit                 is_tick;
      bit [INDEX_W-1:0]   idx;
      bit [RANGE_W-1:0]   rng;
      bit                 finite;
      bit                 last;
   } beam_item_type;

   typedef struct {
      lbg_drive_state_type state;
      bit [CMD_W-1:0]      lin;
      bit [CMD_W-1:0]      ang;
      bit                  turn_left;
   } drive_cmd_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   wire                      req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     req_tlast  = 1'b0;
   wire                      rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_valid  = 1'b0;
   wire                      csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index  = '0;
   logic [CSR_DATA_W-1:0]    csr_data   = '0;

   laser_bump_go_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the registers, at their reset values.
   bit [RANGE_W-1:0]    cfg_floor     = 16'd100;
   bit [RANGE_W-1:0]    cfg_ceiling   = 16'd30000;
   bit [RANGE_W-1:0]    cfg_obstacle  = 16'd1000;
   bit [TICK_W-1:0]     cfg_timeout   = 16'd20;
   bit [TICK_W-1:0]     cfg_backing   = 16'd40;
   bit [SPEED_W-1:0]    cfg_speed_lin = 12'd300;
   bit [SPEED_W-1:0]    cfg_speed_ang = 12'd300;
   bit [INDEX_W-1:0]    cfg_zero_idx  = 10'd333;

   // Predicted controller state.
   lbg_drive_state_type drive_mode    = DRIVE_FORWARD;
   bit                  turn_pos      = 1'b1;
   bit [TICK_W-1:0]     mode_ticks    = '0;
   bit [TICK_W-1:0]     scan_age      = '0;
   bit                  scan_seen     = 1'b0;
   bit [CONE_W-1:0]     run_cone_min  = CONE_INF;
   bit [RANGE_W-1:0]    run_all_max   = '0;
   bit [INDEX_W-1:0]    run_all_idx   = '0;
   bit [RANGE_W-1:0]    run_out_max   = '0;
   bit [INDEX_W-1:0]    run_out_idx   = '0;
   bit                  held_obstacle = 1'b0;
   bit [INDEX_W-1:0]    held_choice   = '0;
   bit [INDEX_W-1:0]    held_max_idx  = '0;

   beam_item_type       beam_queue[$];
   drive_cmd_type       drive_expect[$];
   beam_item_type       drv_item;
   int                  idle_pct      = 9;
   int                  n_queued      = 0;
   int                  n_sent        = 0;
   int                  n_cmds        = 0;
   int                  n_settings    = 1;
   int                  err_count     = 0;
   int                  idle_cycles   = 0;
   int                  state_hits[4] = '{0, 0, 0, 0};

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      err_count++;
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, bit [15:0] val);
      case (idx)
         CSR_RANGE_FLOOR:   cfg_floor     = val;
         CSR_RANGE_CEILING: cfg_ceiling   = val;
         CSR_OBSTACLE_DIST: cfg_obstacle  = val;
         CSR_SCAN_TIMEOUT:  cfg_timeout   = val;
         CSR_BACKING_TICKS: cfg_backing   = val;
         CSR_LIN_SPEED:     cfg_speed_lin = val[SPEED_W-1:0];
         CSR_ANG_SPEED:     cfg_speed_ang = val[SPEED_W-1:0];
         CSR_ZERO_ANGLE:    cfg_zero_idx  = val[INDEX_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void absorb_sample(bit [INDEX_W-1:0] idx, bit [RANGE_W-1:0] rng,
                                         bit finite, bit last);
      bit in_cone;
      bit obst;
      bit max_in_cone;
      in_cone = idx >= CONE_LOW && idx <= CONE_HIGH;
      if (finite && rng >= cfg_floor && rng <= cfg_ceiling) begin
         if (in_cone && {1'b0, rng} < run_cone_min)
            run_cone_min = {1'b0, rng};
         // Strict compares keep the earliest of equal maxima.
         if (rng > run_all_max) begin
            run_all_max = rng;
            run_all_idx = idx;
         end
         if (!in_cone && rng > run_out_max) begin
            run_out_max = rng;
            run_out_idx = idx;
         end
      end
      if (last) begin
         obst          = run_cone_min < {1'b0, cfg_obstacle};
         max_in_cone   = run_all_idx >= CONE_LOW && run_all_idx <= CONE_HIGH;
         held_obstacle = obst;
         held_max_idx  = run_all_idx;
         held_choice   = (obst && max_in_cone && run_out_max != 0) ? run_out_idx
                                                                    : run_all_idx;
         run_cone_min  = CONE_INF;
         run_all_max   = '0;
         run_all_idx   = '0;
         run_out_max   = '0;
         run_out_idx   = '0;
         scan_seen     = 1'b1;
         scan_age      = '0;
      end
   endfunction

   function automatic void switch_mode(lbg_drive_state_type next_mode);
      drive_mode = next_mode;
      mode_ticks = '0;
   endfunction

   function automatic void advance_drive();
      drive_cmd_type    cmd;
      bit [INDEX_W-1:0] centre_gap;
      if (!scan_seen)
         return;
      if (scan_age != TICK_SAT)
         scan_age++;
      if (mode_ticks != TICK_SAT)
         mode_ticks++;
      cmd.lin = '0;
      cmd.ang = '0;
      case (drive_mode)
         DRIVE_FORWARD: begin
            cmd.lin = {1'b0, cfg_speed_lin};
            if (scan_age > cfg_timeout) begin
               switch_mode(DRIVE_STOP);
            end else begin
               turn_pos = held_choice >= cfg_zero_idx;
               if (held_obstacle)
                  switch_mode(DRIVE_BACK);
            end
         end
         DRIVE_BACK: begin
            cmd.lin = 13'd0 - {1'b0, cfg_speed_lin};
            if (mode_ticks > cfg_backing)
               switch_mode(DRIVE_TURN);
         end
         DRIVE_TURN: begin
            cmd.ang = turn_pos ? {1'b0, cfg_speed_ang} : 13'd0 - {1'b0, cfg_speed_ang};
            centre_gap = held_max_idx >= CENTER_INDEX ? held_max_idx - CENTER_INDEX
                                                      : CENTER_INDEX - held_max_idx;
            if (centre_gap <= CENTER_TOLERANCE)
               switch_mode(DRIVE_FORWARD);
         end
         default: begin
            if (scan_age < cfg_timeout)
               switch_mode(DRIVE_FORWARD);
         end
      endcase
      cmd.state     = drive_mode;
      cmd.turn_left = turn_pos;
      state_hits[drive_mode]++;
      drive_expect.push_back(cmd);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_sample(bit [INDEX_W-1:0] idx, bit [RANGE_W-1:0] rng,
                                       bit finite, bit last);
      beam_item_type item;
      item.is_tick = 1'b0;
      item.idx     = idx;
      item.rng     = rng;
      item.finite  = finite;
      item.last    = last;
      beam_queue.push_back(item);
      n_queued++;
   endfunction

   // Ticks carry random sample fields, which the block must ignore.
   function automatic void push_tick();
      beam_item_type item;
      item.is_tick = 1'b1;
      item.idx     = INDEX_W'($urandom);
      item.rng     = RANGE_W'($urandom);
      item.finite  = 1'($urandom);
      item.last    = 1'($urandom);
      beam_queue.push_back(item);
      n_queued++;
   endfunction

   function automatic void queue_ticks(int count);
      repeat (count) push_tick();
   endfunction

   function automatic bit [RANGE_W-1:0] pick_range(bit [RANGE_W-1:0] prev);
      case ($urandom_range(9))
         0: return cfg_floor;
         1: return cfg_ceiling;
         2: return cfg_floor - 16'd1;
         3: return cfg_ceiling + 16'd1;
         4: return cfg_obstacle - 16'd1;
         5: return cfg_obstacle;
         6: return RANGE_W'($urandom);
         7: return prev;
         default: return RANGE_W'($urandom_range(cfg_ceiling, cfg_floor));
      endcase
   endfunction

   // One scan in beam order, mostly valid samples, with a fair chance of a
   // beam near the centre so that a turn can come to an end.
   function automatic void queue_scan();
      bit [INDEX_W-1:0] spots[$];
      bit [RANGE_W-1:0] rng;
      int               len;
      len = $urandom_range(14, 2);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(1))
            spots.push_back(INDEX_W'($urandom_range(CONE_HIGH, CONE_LOW)));
         else
            spots.push_back(INDEX_W'($urandom_range(1023)));
      end
      if ($urandom_range(3) == 0)
         spots.push_back(CENTER_INDEX - CENTER_TOLERANCE - 10'd1 + INDEX_W'($urandom_range(8)));
      spots.sort();
      rng = cfg_ceiling;
      foreach (spots[i]) begin
         if (spots[i] >= CENTER_INDEX - CENTER_TOLERANCE &&
             spots[i] <= CENTER_INDEX + CENTER_TOLERANCE && $urandom_range(1))
            rng = cfg_ceiling;
         else
            rng = pick_range(rng);
         if ($urandom_range(29) == 0)
            push_tick();
         push_sample(spots[i], rng, $urandom_range(19) != 0, i == spots.size() - 1);
      end
   endfunction

   function automatic void queue_traffic(int count);
      int goal;
      int pick;
      goal = n_queued + count;
      while (n_queued < goal) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            queue_scan();
            queue_ticks($urandom_range(6));
         end else if (pick < 80) begin
            queue_ticks($urandom_range(30, 1));
         end else begin
            repeat ($urandom_range(6, 1)) begin
               if ($urandom_range(1))
                  push_tick();
               else
                  push_sample(INDEX_W'($urandom), RANGE_W'($urandom), 1'($urandom),
                              $urandom_range(3) == 0);
            end
         end
      end
   endfunction

   // Called at a rising edge; returns at the edge where the write is taken.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input bit [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_reg(idx, val);
   endtask

   task automatic program_regs(input bit [15:0] rmin, input bit [15:0] rmax,
                               input bit [15:0] obst, input bit [15:0] tmo,
                               input bit [15:0] back, input bit [15:0] slin,
                               input bit [15:0] sang, input bit [15:0] zero);
      write_reg(CSR_RANGE_FLOOR, rmin);
      write_reg(CSR_RANGE_CEILING, rmax);
      write_reg(CSR_OBSTACLE_DIST, obst);
      write_reg(CSR_SCAN_TIMEOUT, tmo);
      write_reg(CSR_BACKING_TICKS, back);
      write_reg(CSR_LIN_SPEED, slin);
      write_reg(CSR_ANG_SPEED, sang);
      write_reg(CSR_ZERO_ANGLE, zero);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // Upper bits of the speed and index values are random so that masking is
   // exercised as well.
   task automatic random_regs();
      program_regs(16'($urandom_range(300)), 16'($urandom_range(65535, 2000)),
                   16'($urandom_range(3000, 200)), 16'($urandom_range(12, 2)),
                   16'($urandom_range(6)), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Samples and publishes give no result, so the block may still be busy
   // when the last command has left; allow it time to settle.
   task automatic wait_quiet();
      do @(posedge clock);
      while (n_sent != n_queued || drive_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed scans under the reset settings.
      push_tick();                                   // no scan yet, no command
      push_sample(10'd0, 16'd0, 1'b1, 1'b0);         // below the lower range limit
      push_sample(10'd100, 16'hFFFF, 1'b1, 1'b0);    // above the upper range limit
      push_sample(10'd250, 16'd700, 1'b0, 1'b0);     // not finite
      push_sample(10'd195, 16'd800, 1'b1, 1'b0);     // just outside the cone
      push_sample(10'd196, 16'd999, 1'b1, 1'b0);     // cone edge, obstacle
      push_sample(10'd300, 16'd30000, 1'b1, 1'b0);   // maximum inside the cone
      push_sample(10'd470, 16'd30000, 1'b1, 1'b0);   // equal range, earlier wins
      push_sample(10'd471, 16'd30000, 1'b1, 1'b0);   // maximum outside the cone
      push_sample(10'd1023, 16'd100, 1'b1, 1'b1);    // lower limit edge, publishes
      push_tick();
      push_tick();
      push_sample(10'd5, 16'd0, 1'b0, 1'b1);         // invalid sample still publishes
      push_tick();
      push_sample(10'd334, 16'd1200, 1'b1, 1'b0);
      push_tick();                                   // tick in the middle of a scan
      push_sample(10'd335, 16'd1200, 1'b1, 1'b0);
      push_sample(10'd600, 16'd500, 1'b1, 1'b0);
      push_sample(10'd700, 16'd1199, 1'b1, 1'b1);
      queue_ticks(4);
      wait_quiet();

      random_regs();
      queue_traffic(170);
      wait_quiet();

      // Lowest settings: only a zero range is valid and it is never a maximum.
      program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_traffic(80);
      wait_quiet();

      // A long stretch with no idling on either side.
      idle_pct = 0;
      random_regs();
      queue_traffic(170);
      wait_quiet();
      idle_pct = 9;

      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF);
      queue_traffic(80);
      wait_quiet();

      for (int p = 0; p < 3; p++) begin
         if (p == 0)
            write_reg(CSR_SPARE, 16'hFFFF);          // unused index, no effect
         random_regs();
         queue_traffic(170);
         wait_quiet();
      end

      $display("Ran %0d requests over %0d register settings; %0d drive commands checked.",
               n_sent, n_settings, n_cmds);
      $display("Commands per state: forward %0d, back %0d, turn %0d, stop %0d.",
               state_hits[DRIVE_FORWARD], state_hits[DRIVE_BACK],
               state_hits[DRIVE_TURN], state_hits[DRIVE_STOP]);
      if (err_count == 0 && drive_expect.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ------------------------------------------------------ driver and monitor

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            n_sent++;
            if (drv_item.is_tick)
               advance_drive();
            else
               absorb_sample(drv_item.idx, drv_item.rng, drv_item.finite, drv_item.last);
         end
         if (!req_tvalid || req_tready) begin
            if (beam_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               drv_item = beam_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drv_item.is_tick;
               req_tlast  <= drv_item.last;
               req_tdata  <= {5'b0, drv_item.finite, drv_item.rng, drv_item.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_command(input logic [RSP_DATA_W-1:0] data);
      drive_cmd_type want;
      if (drive_expect.size() == 0) begin
         report_mismatch("drive command with none predicted", data, 0);
         return;
      end
      want = drive_expect.pop_front();
      if (data[1:0] !== want.state)
         report_mismatch("drive_state", data[1:0], want.state);
      if (data[14:2] !== want.lin)
         report_mismatch("linear_cmd", data[14:2], want.lin);
      if (data[27:15] !== want.ang)
         report_mismatch("angular_cmd", data[27:15], want.ang);
      if (data[28] !== want.turn_left)
         report_mismatch("turn_left", data[28], want.turn_left);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_cmds++;
            check_command(rsp_tdata);
         end
         rsp_tready <= $urandom_range(99) >= idle_pct;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d commands outstanding.",
                  STALL_LIMIT, drive_expect.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// File: files.f
rtl/lbg_pkg.sv
rtl/lbg_front.sv
rtl/lbg_queue.sv
rtl/lbg_back.sv
rtl/laser_bump_go_controller.sv
tb/laser_bump_go_controller_test.sv
